FILE: src/hsbr_pkg.sv
`default_nettype none
package hsbr_pkg;

  localparam logic [15:0] TIMEOUT_RESET = 16'd60000;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_BIT_LOW  = 3'd1,
    PH_BIT_HIGH = 3'd2,
    PH_PRE_ACK  = 3'd3,
    PH_ACK_HIGH = 3'd4,
    PH_LAST_LOW = 3'd5
  } phase_t;

  typedef struct packed {
    logic arm;
    logic scl_in;
    logic sda_in;
  } in_item_t;

  typedef struct packed {
    logic       ack_line;
    logic       busy_res;
    logic       byte_done;
    logic [7:0] byte_value;
    logic       timed_out;
    logic [2:0] fail_stage;
  } out_item_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  bit_count;
    logic [7:0]  shift_reg;
    logic [15:0] wait_ticks;
    logic        ack_reg;
  } rx_state_t;

endpackage
`default_nettype wire

FILE: src/hsbr_step.sv
`default_nettype none
module hsbr_step (
  input  hsbr_pkg::rx_state_t  cur,
  input  hsbr_pkg::in_item_t   item,
  input  logic [15:0]          limit,
  output hsbr_pkg::rx_state_t  nxt,
  output hsbr_pkg::out_item_t  res
);
  import hsbr_pkg::*;

  logic        want;
  logic        met;
  logic [16:0] ticks_inc;
  logic        expire;

  assign want      = (cur.phase == PH_BIT_HIGH) || (cur.phase == PH_ACK_HIGH);
  assign met       = (item.scl_in == want);
  assign ticks_inc = {1'b0, cur.wait_ticks} + 17'd1;
  assign expire    = (ticks_inc >= {1'b0, limit});

  // next state
  always_comb begin
    nxt = cur;
    unique case (cur.phase)
      PH_BIT_LOW, PH_BIT_HIGH, PH_PRE_ACK, PH_ACK_HIGH, PH_LAST_LOW: begin
        if (met) begin
          nxt.wait_ticks = '0;
          unique case (cur.phase)
            PH_BIT_LOW: nxt.phase = PH_BIT_HIGH;
            PH_BIT_HIGH: begin
              nxt.shift_reg = {cur.shift_reg[6:0], item.sda_in};
              if (cur.bit_count == 3'd7) begin
                nxt.bit_count = '0;
                nxt.phase     = PH_PRE_ACK;
              end else begin
                nxt.bit_count = cur.bit_count + 3'd1;
                nxt.phase     = PH_BIT_LOW;
              end
            end
            PH_PRE_ACK: begin
              nxt.ack_reg = 1'b0;
              nxt.phase   = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: nxt.phase = PH_LAST_LOW;
            default: begin
              nxt.ack_reg = 1'b1;
              nxt.phase   = PH_IDLE;
            end
          endcase
        end else if (expire) begin
          nxt.ack_reg    = 1'b1;
          nxt.wait_ticks = '0;
          nxt.phase      = PH_IDLE;
        end else begin
          nxt.wait_ticks = ticks_inc[15:0];
        end
      end
      default: begin
        // idle and unused codes
        nxt.phase = PH_IDLE;
        if (item.arm) begin
          nxt.phase      = PH_BIT_LOW;
          nxt.bit_count  = '0;
          nxt.shift_reg  = '0;
          nxt.wait_ticks = '0;
          nxt.ack_reg    = 1'b1;
        end
      end
    endcase
  end

  // result
  always_comb begin
    res            = '0;
    res.ack_line   = nxt.ack_reg;
    res.busy_res   = (nxt.phase != PH_IDLE);
    unique case (cur.phase)
      PH_BIT_LOW, PH_BIT_HIGH, PH_PRE_ACK, PH_ACK_HIGH, PH_LAST_LOW: begin
        if (met) begin
          if (cur.phase == PH_LAST_LOW) begin
            res.byte_done  = 1'b1;
            res.byte_value = cur.shift_reg;
          end
        end else if (expire) begin
          res.byte_done  = 1'b1;
          res.timed_out  = 1'b1;
          res.fail_stage = cur.phase - 3'd1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/handshake_serial_byte_receiver.sv
// result of an input transfer is registered, valid in the next cycle
// one tick per cycle while not stalled; state and result reg update together
// in_ready stays high while the result register is empty or being taken
// reset (rst_n low, synchronous): idle, ack released, limit 60000, no result
`default_nettype none
module handshake_serial_byte_receiver (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsbr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hsbr_pkg::out_item_t out_data
);
  import hsbr_pkg::*;

  logic [15:0] limit_r;
  rx_state_t   state_r;
  rx_state_t   state_nxt;
  out_item_t   res_nxt;
  out_item_t   res_r;
  logic        valid_r;
  logic        in_xfer;

  assign in_ready  = !valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = valid_r;
  assign out_data  = res_r;

  hsbr_step u_step (
    .cur   (state_r),
    .item  (in_data),
    .limit (limit_r),
    .nxt   (state_nxt),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r            <= TIMEOUT_RESET;
      state_r.phase      <= PH_IDLE;
      state_r.bit_count  <= '0;
      state_r.shift_reg  <= '0;
      state_r.wait_ticks <= '0;
      state_r.ack_reg    <= 1'b1;
      valid_r            <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (in_xfer) begin
        state_r <= state_nxt;
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: tb/handshake_serial_byte_receiver_tb.sv
`default_nettype none
module handshake_serial_byte_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsbr_pkg::*;

  class rx_byte_tracker;
    logic [15:0] limit;
    phase_t      phase;
    logic [2:0]  bit_cnt;
    logic [7:0]  shift;
    logic [15:0] ticks;
    logic        ack;
    out_item_t   due_results[$];
    int          errors;

    function new();
      limit   = TIMEOUT_RESET;
      phase   = PH_IDLE;
      bit_cnt = '0;
      shift   = '0;
      ticks   = '0;
      ack     = 1'b1;
      errors  = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void note_tick(in_item_t t);
      out_item_t   e;
      logic        want;
      logic [16:0] nxt;
      e = '0;
      if (phase == PH_IDLE) begin
        if (t.arm) begin
          phase   = PH_BIT_LOW;
          bit_cnt = '0;
          shift   = '0;
          ticks   = '0;
          ack     = 1'b1;
        end
      end else begin
        want = (phase == PH_BIT_HIGH || phase == PH_ACK_HIGH);
        if (t.scl_in == want) begin
          ticks = '0;
          case (phase)
            PH_BIT_LOW: phase = PH_BIT_HIGH;
            PH_BIT_HIGH: begin
              shift = {shift[6:0], t.sda_in};
              if (bit_cnt == 3'd7) begin
                bit_cnt = '0;
                phase   = PH_PRE_ACK;
              end else begin
                bit_cnt = bit_cnt + 3'd1;
                phase   = PH_BIT_LOW;
              end
            end
            PH_PRE_ACK: begin
              ack   = 1'b0;
              phase = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: phase = PH_LAST_LOW;
            default: begin
              ack          = 1'b1;
              e.byte_done  = 1'b1;
              e.byte_value = shift;
              phase        = PH_IDLE;
            end
          endcase
        end else begin
          nxt = {1'b0, ticks} + 17'd1;
          if (nxt >= {1'b0, limit}) begin
            e.byte_done  = 1'b1;
            e.timed_out  = 1'b1;
            e.fail_stage = phase - 3'd1;
            ack          = 1'b1;
            ticks        = '0;
            phase        = PH_IDLE;
          end else begin
            ticks = nxt[15:0];
          end
        end
      end
      e.ack_line = ack;
      e.busy_res = (phase != PH_IDLE);
      due_results.push_back(e);
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s expected %0h actual %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (due_results.size() == 0) begin
        $error("result with no tick pending: %p", got);
        errors++;
        return;
      end
      e = due_results.pop_front();
      compare_field("ack_line", 8'(e.ack_line), 8'(got.ack_line));
      compare_field("busy_res", 8'(e.busy_res), 8'(got.busy_res));
      compare_field("byte_done", 8'(e.byte_done), 8'(got.byte_done));
      compare_field("byte_value", e.byte_value, got.byte_value);
      compare_field("timed_out", 8'(e.timed_out), 8'(got.timed_out));
      compare_field("fail_stage", 8'(e.fail_stage), 8'(got.fail_stage));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  rx_byte_tracker rx_sb = new();
  in_item_t       tick_q[$];
  int             src_idle_pct = 0;
  int             dst_stall_pct = 0;
  int             hold_left = 0;

  handshake_serial_byte_receiver uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) rx_sb.note_tick(in_data);
    if (rst_n && out_valid && out_ready) rx_sb.check_result(out_data);
  end

  // result side: long hold-off when requested, else random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= dst_stall_pct);
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL handshake_serial_byte_receiver");
    $finish;
  end

  function automatic void add_tick(logic arm, logic scl, logic sda);
    in_item_t t;
    t.arm    = arm;
    t.scl_in = scl;
    t.sda_in = sda;
    tick_q.push_back(t);
  endfunction

  // one clock level wait; a broken wait sees only the wrong level until timeout
  function automatic bit add_wait(logic level, logic sda, int lim, bit breaks);
    int gap;
    int maxg;
    maxg = (lim <= 1) ? 0 : ((lim - 1 > 5) ? 5 : lim - 1);
    if (breaks) gap = (lim < 1) ? 1 : lim;
    else if (lim > 1 && lim <= 64 && $urandom_range(7) == 0) gap = lim - 1;
    else gap = $urandom_range(maxg);
    repeat (gap) add_tick(1'($urandom_range(1)), ~level, 1'($urandom_range(1)));
    if (!breaks) add_tick(1'($urandom_range(1)), level, sda);
    return breaks;
  endfunction

  function automatic void add_frame(int lim, bit broken);
    logic [7:0] b;
    phase_t     brk_ph;
    int         brk_bit;
    b       = 8'($urandom_range(255));
    brk_ph  = broken ? phase_t'(PH_BIT_LOW + $urandom_range(4)) : PH_IDLE;
    brk_bit = $urandom_range(7);
    add_tick(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
    for (int i = 7; i >= 0; i--) begin
      if (add_wait(1'b0, 1'($urandom_range(1)), lim, brk_ph == PH_BIT_LOW && brk_bit == i))
        return;
      if (add_wait(1'b1, b[i], lim, brk_ph == PH_BIT_HIGH && brk_bit == i)) return;
    end
    if (add_wait(1'b0, 1'($urandom_range(1)), lim, brk_ph == PH_PRE_ACK)) return;
    if (add_wait(1'b1, 1'($urandom_range(1)), lim, brk_ph == PH_ACK_HIGH)) return;
    void'(add_wait(1'b0, 1'($urandom_range(1)), lim, brk_ph == PH_LAST_LOW));
  endfunction

  task automatic drive_ticks(input int count);
    in_item_t t;
    int       sent;
    sent = 0;
    while (tick_q.size() > 0 && sent < count) begin
      if ($urandom_range(99) < src_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end else begin
        t = tick_q.pop_front();
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (rx_sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    rx_sb.limit = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int         limits[7] = '{1, 0, 5, 65535, 2, 12, 1};
    logic [7:0] pat;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero-gap byte at the reset limit, arm held high while busy
    pat = 8'hA5;
    add_tick(1'b0, 1'b1, 1'b1);
    add_tick(1'b1, 1'b0, 1'b0);
    for (int i = 7; i >= 0; i--) begin
      add_tick(1'b1, 1'b0, ~pat[i]);
      add_tick(1'b1, 1'b1, pat[i]);
    end
    add_tick(1'b1, 1'b0, 1'b1);
    add_tick(1'b1, 1'b1, 1'b1);
    add_tick(1'b1, 1'b0, 1'b0);
    drive_ticks(tick_q.size());
    wait_drain();

    for (int p = 0; p < 7; p++) begin
      write_limit(16'(limits[p]));
      case (p % 4)
        0: begin
          src_idle_pct  = 0;
          dst_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 81;
          dst_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          dst_stall_pct = 81;
        end
        default: begin
          src_idle_pct  = 28;
          dst_stall_pct = 28;
        end
      endcase
      while (tick_q.size() < 185) begin
        add_frame(limits[p], limits[p] <= 64 && $urandom_range(99) < 30);
        if ($urandom_range(4) == 0)
          repeat ($urandom_range(1, 6))
            add_tick($urandom_range(7) == 0, 1'($urandom_range(1)), 1'($urandom_range(1)));
        else if ($urandom_range(2) == 0)
          repeat ($urandom_range(1, 3))
            add_tick(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      if (p == 4) begin
        // hold off the result side so the block backs up its input
        hold_left = 300;
        drive_ticks(tick_q.size() / 2);
        wait_drain();
      end
      drive_ticks(tick_q.size());
      wait_drain();
    end

    repeat (4) @(posedge clk);
    if (rx_sb.errors == 0 && rx_sb.pending() == 0) begin
      $display("PASS handshake_serial_byte_receiver");
    end else begin
      $display("FAIL handshake_serial_byte_receiver");
    end
    $finish;
  end

endmodule
`default_nettype wire
